>>> hw/rtl/chd_pkg.sv
// Shared types and constants for the HTTP chunked body decoder.
// No dependencies; the parser, the top level and the testbench import this package.
package chd_pkg;

	// Width of the chunk size counter; the size saturates at all ones.
	localparam int SIZE_BITS = 32;

	// End status codes reported with the body's last byte.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_TRUNC  = 2'd1;
	localparam logic [1:0] ST_NOCRLF = 2'd2;

	// Line terminator and white space bytes.
	localparam logic [7:0] CH_CR  = 8'h0d;
	localparam logic [7:0] CH_LF  = 8'h0a;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;

	// Result of parsing one byte, from the parser to the output register.
	typedef struct packed {
		logic       has_result;
		logic [7:0] payload_byte;
		logic       payload_valid;
		logic       body_done;
		logic [1:0] end_status;
	} chd_result_t;

endpackage

>>> hw/rtl/chd_body_if.sv
// Input channel of the chunked body decoder: one raw body byte per item.
// Depends on nothing.
interface chd_body_if;
	logic       valid;
	logic       ready;
	logic [7:0] body_byte;
	logic       body_last;

	modport source (output valid, output body_byte, output body_last, input ready);
	modport sink (input valid, input body_byte, input body_last, output ready);
endinterface

>>> hw/rtl/chd_payload_if.sv
// Output channel of the chunked body decoder: payload byte and end status.
// Depends on nothing.
interface chd_payload_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       payload_valid;
	logic       body_done;
	logic [1:0] end_status;

	modport source (output valid, output payload_byte, output payload_valid,
		output body_done, output end_status, input ready);
	modport sink (input valid, input payload_byte, input payload_valid,
		input body_done, input end_status, output ready);
endinterface

>>> hw/rtl/chd_in_stage.sv
// Input register of the chunked body decoder.
// Depends on chd_body_if.
module chd_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	chd_body_if.sink   body,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1,
	output logic       last_s1
);

	logic take;

	// Take a new item when the stage is empty or its item moves on now
	assign body.ready = !valid_s1 || advance;
	assign take = body.valid && body.ready;

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (body.ready) begin
			valid_s1 <= body.valid;
		end
	end

	// Capture payload
	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= body.body_byte;
			last_s1 <= body.body_last;
		end
	end

endmodule

>>> hw/rtl/chd_parser.sv
// Chunk size line and data parser; holds the decoder state.
// Depends on chd_pkg.
module chd_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           in_byte,
	input  logic                 in_last,
	input  logic                 advance,
	output chd_pkg::chd_result_t result
);
	import chd_pkg::*;

	typedef enum logic [2:0] {
		M_SIZE,
		M_SIZE_LF,
		M_DATA,
		M_DATA_CR,
		M_DATA_LF,
		M_DONE
	} mode_t;

	mode_t                mode_q, mode_d;
	logic [SIZE_BITS-1:0] size_q, size_d;
	logic                 ended_q, ended_d;
	logic                 saw_q, saw_d;
	logic [1:0]           err_q, err_d;
	logic                 emit;
	logic                 is_hex;
	logic [3:0]           nib;
	logic                 live;

	// Decode a hex digit
	always_comb begin
		is_hex = 1'b1;
		nib = 4'd0;
		if (in_byte inside {[8'h30:8'h39]}) begin
			nib = in_byte[3:0];
		end else if (in_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			nib = in_byte[3:0] + 4'd9;
		end else begin
			is_hex = 1'b0;
		end
	end

	// Advance the parse mode for one byte
	always_comb begin
		mode_d  = mode_q;
		size_d  = size_q;
		ended_d = ended_q;
		saw_d   = saw_q;
		err_d   = err_q;
		emit    = 1'b0;
		case (mode_q)
			M_SIZE: begin
				if (in_byte == CH_CR) begin
					ended_d = ended_q | saw_q;
					mode_d = M_SIZE_LF;
				end else if (ended_q) begin
					ended_d = 1'b1;
				end else if (!saw_q && (in_byte == CH_SP || in_byte == CH_TAB)) begin
					saw_d = 1'b0;
				end else if (!is_hex) begin
					ended_d = 1'b1;
				end else begin
					saw_d = 1'b1;
					// Saturate when a shift by one digit would overflow
					if (size_q[SIZE_BITS-1 -: 4] != 4'd0) begin
						size_d = '1;
					end else begin
						size_d = {size_q[SIZE_BITS-5:0], nib};
					end
				end
			end
			M_SIZE_LF: begin
				if (in_byte == CH_LF) begin
					if (size_q == '0) begin
						mode_d = M_DONE;
						err_d = ST_OK;
					end else begin
						mode_d = M_DATA;
					end
				end else if (in_byte == CH_CR) begin
					ended_d = 1'b1;
				end else begin
					ended_d = 1'b1;
					mode_d = M_SIZE;
				end
			end
			M_DATA: begin
				emit = 1'b1;
				size_d = size_q - SIZE_BITS'(1);
				if (size_q == SIZE_BITS'(1)) begin
					mode_d = M_DATA_CR;
				end
			end
			M_DATA_CR: begin
				if (in_byte == CH_CR) begin
					mode_d = M_DATA_LF;
				end else begin
					mode_d = M_DONE;
					err_d = ST_NOCRLF;
				end
			end
			M_DATA_LF: begin
				if (in_byte == CH_LF) begin
					mode_d = M_SIZE;
					size_d = '0;
					ended_d = 1'b0;
					saw_d = 1'b0;
				end else begin
					mode_d = M_DONE;
					err_d = ST_NOCRLF;
				end
			end
			default: begin
				mode_d = mode_q;
			end
		endcase
	end

	// Build the result; any mode outside the parsing ones counts as stopped
	assign live = (mode_d == M_SIZE) || (mode_d == M_SIZE_LF) || (mode_d == M_DATA) ||
		(mode_d == M_DATA_CR) || (mode_d == M_DATA_LF);

	always_comb begin
		result.has_result    = emit || in_last;
		result.payload_byte  = emit ? in_byte : 8'd0;
		result.payload_valid = emit;
		result.body_done     = in_last;
		result.end_status    = !in_last ? ST_OK : (live ? ST_TRUNC : err_d);
	end

	// Hold state; drop back to a fresh body after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_SIZE;
			size_q  <= '0;
			ended_q <= 1'b0;
			saw_q   <= 1'b0;
			err_q   <= ST_OK;
		end else if (advance) begin
			if (in_last) begin
				mode_q  <= M_SIZE;
				size_q  <= '0;
				ended_q <= 1'b0;
				saw_q   <= 1'b0;
				err_q   <= ST_OK;
			end else begin
				mode_q  <= mode_d;
				size_q  <= size_d;
				ended_q <= ended_d;
				saw_q   <= saw_d;
				err_q   <= err_d;
			end
		end
	end

endmodule

>>> hw/rtl/http_chunked_body_decoder.sv
// Top level of the HTTP chunked body decoder: input register, parser, result register.
// Depends on chd_pkg, chd_body_if, chd_payload_if, chd_in_stage and chd_parser.
//
//   channel   dir   handshake      item contents
//   body      in    valid/ready    body_byte, body_last
//   payload   out   valid/ready    payload_byte, payload_valid, body_done, end_status
//
// One body byte per cycle sustained unless the payload channel stalls. The parser
// updates mode and size counter between the input register and the result register.
// Reset clears all control state; no clearing pass is needed.
// A stalled payload channel holds the result register, and the input register
// then fills and stalls the body channel; bytes that give no result still pass.
module http_chunked_body_decoder (
	input  logic          clk,
	input  logic          arst_n,
	chd_body_if.sink      body,
	chd_payload_if.source payload
);
	import chd_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        advance;
	logic        out_free;
	chd_result_t result;
	logic        out_valid_q;
	logic [7:0]  payload_byte_q;
	logic        payload_valid_q;
	logic        body_done_q;
	logic [1:0]  end_status_q;

	// The result register is free when empty or being taken this cycle
	assign out_free = !out_valid_q || payload.ready;
	assign advance  = valid_s1 && (out_free || !result.has_result);

	chd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.body     (body),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.last_s1  (last_s1)
	);

	chd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_byte (byte_s1),
		.in_last (last_s1),
		.advance (advance),
		.result  (result)
	);

	// Hold the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1 && result.has_result;
		end
	end

	// Load result payload
	always_ff @(posedge clk) begin
		if (out_free && valid_s1 && result.has_result) begin
			payload_byte_q  <= result.payload_byte;
			payload_valid_q <= result.payload_valid;
			body_done_q     <= result.body_done;
			end_status_q    <= result.end_status;
		end
	end

	assign payload.valid         = out_valid_q;
	assign payload.payload_byte  = payload_byte_q;
	assign payload.payload_valid = payload_valid_q;
	assign payload.body_done     = body_done_q;
	assign payload.end_status    = end_status_q;

	// Every result carries a payload byte or closes the body
	a_result_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		payload.valid |-> (payload.payload_valid || payload.body_done))
		else $error("result with neither payload nor body end");

	// Status is only reported with the body's last byte
	a_status_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(payload.valid && !payload.body_done) |-> (payload.end_status == ST_OK))
		else $error("end status set before body end");

	// A byte without payload meaning is zero
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(payload.valid && !payload.payload_valid) |-> (payload.payload_byte == 8'd0))
		else $error("payload byte set without payload");

	// A waiting result is not overwritten by the parser
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !payload.ready) |=> (out_valid_q && $stable(end_status_q)))
		else $error("stalled result lost");

endmodule

>>> tb/tb_http_chunked_body_decoder.sv
// Testbench for http_chunked_body_decoder: directed and random chunked bodies,
// checked item by item against a scoreboard that tracks the size-line parser.
// Depends on chd_pkg, chd_body_if, chd_payload_if and the decoder RTL.
module tb_http_chunked_body_decoder;
	import chd_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam logic [SIZE_BITS-1:0] SIZE_ALL_ONES = '1;

	typedef enum logic [2:0] {
		MODE_SIZE,
		MODE_SIZE_LF,
		MODE_DATA,
		MODE_DATA_CR,
		MODE_DATA_LF,
		MODE_DONE
	} parse_mode_e;

	typedef struct packed {
		logic [7:0] data;
		logic       data_valid;
		logic       done;
		logic [1:0] status;
	} payload_item_t;

	// Track the parser state and hold the payload items it should produce
	class chunk_scoreboard;
		parse_mode_e          mode;
		logic [SIZE_BITS-1:0] remaining;
		logic                 digits_ended;
		logic                 saw_digit;
		logic [1:0]           err_latch;
		payload_item_t        payload_q[$];
		int                   errors;

		function new();
			errors = 0;
			restart_body();
		endfunction

		function void begin_line();
			mode = MODE_SIZE;
			remaining = '0;
			digits_ended = 1'b0;
			saw_digit = 1'b0;
		endfunction

		function void restart_body();
			begin_line();
			err_latch = ST_OK;
		endfunction

		function int hex_value(input logic [7:0] b);
			if (b >= "0" && b <= "9") return int'(b) - int'("0");
			if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
			if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
			return -1;
		endfunction

		function int pending();
			return payload_q.size();
		endfunction

		// Advance the parser by one accepted body item
		function void note_body(input logic [7:0] b, input logic last);
			payload_item_t        res;
			logic                 emit;
			int                   nib;
			logic [SIZE_BITS-1:0] digit;
			emit = 1'b0;
			nib = hex_value(b);
			digit = SIZE_BITS'(nib < 0 ? 0 : nib);
			case (mode)
			MODE_SIZE: begin
				if (b == CH_CR) begin
					digits_ended = digits_ended | saw_digit;
					mode = MODE_SIZE_LF;
				end else if (!digits_ended && (saw_digit || (b != CH_SP && b != CH_TAB))) begin
					if (nib < 0) begin
						digits_ended = 1'b1;
					end else begin
						saw_digit = 1'b1;
						// saturate instead of wrapping
						if (remaining > ((SIZE_ALL_ONES - digit) >> 4))
							remaining = SIZE_ALL_ONES;
						else
							remaining = (remaining << 4) + digit;
					end
				end
			end
			MODE_SIZE_LF: begin
				if (b == CH_LF) begin
					if (remaining == '0) begin
						mode = MODE_DONE;
						err_latch = ST_OK;
					end else begin
						mode = MODE_DATA;
					end
				end else if (b == CH_CR) begin
					digits_ended = 1'b1;
				end else begin
					// lone CR: back to the size line, digits closed
					digits_ended = 1'b1;
					mode = MODE_SIZE;
				end
			end
			MODE_DATA: begin
				emit = 1'b1;
				remaining = remaining - SIZE_BITS'(1);
				if (remaining == '0)
					mode = MODE_DATA_CR;
			end
			MODE_DATA_CR: begin
				if (b == CH_CR) begin
					mode = MODE_DATA_LF;
				end else begin
					mode = MODE_DONE;
					err_latch = ST_NOCRLF;
				end
			end
			MODE_DATA_LF: begin
				if (b == CH_LF) begin
					begin_line();
				end else begin
					mode = MODE_DONE;
					err_latch = ST_NOCRLF;
				end
			end
			default: begin
			end
			endcase

			if (emit || last) begin
				res.data = emit ? b : 8'h00;
				res.data_valid = emit;
				res.done = last;
				res.status = ST_OK;
				if (last)
					res.status = (mode >= MODE_DONE) ? err_latch : ST_TRUNC;
				payload_q.push_back(res);
			end
			if (last)
				restart_body();
		endfunction

		// Compare one accepted payload item with the oldest expectation
		function void check_payload(input payload_item_t got);
			payload_item_t want;
			if (payload_q.size() == 0) begin
				$error("unexpected payload item: byte %0h valid %0b done %0b status %0d",
					got.data, got.data_valid, got.done, got.status);
				errors++;
				return;
			end
			want = payload_q.pop_front();
			if (got.data !== want.data) begin
				$error("payload_byte: expected %0h, actual %0h", want.data, got.data);
				errors++;
			end
			if (got.data_valid !== want.data_valid) begin
				$error("payload_valid: expected %0b, actual %0b", want.data_valid, got.data_valid);
				errors++;
			end
			if (got.done !== want.done) begin
				$error("body_done: expected %0b, actual %0b", want.done, got.done);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("end_status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	chd_body_if    body_ch();
	chd_payload_if pay_ch();

	http_chunked_body_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.body    (body_ch),
		.payload (pay_ch)
	);

	chunk_scoreboard sb;
	logic [7:0]      body_q[$];
	int              in_idle_pct;
	int              out_stall_pct;
	int              hold_cnt;
	int              quiet_cycles;

	always #5 clk = ~clk;

	// Drive payload ready: a long hold-off while the hold count runs, random stalls otherwise
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			pay_ch.ready <= 1'b0;
			hold_cnt = hold_cnt - 1;
		end else begin
			pay_ch.ready <= ($urandom_range(99) >= out_stall_pct);
		end
	end

	// Note accepted body items and check accepted payload items
	always @(posedge clk) begin : monitor
		payload_item_t got;
		if (arst_n) begin
			if (body_ch.valid && body_ch.ready)
				sb.note_body(body_ch.body_byte, body_ch.body_last);
			if (pay_ch.valid && pay_ch.ready) begin
				got.data = pay_ch.payload_byte;
				got.data_valid = pay_ch.payload_valid;
				got.done = pay_ch.body_done;
				got.status = pay_ch.end_status;
				sb.check_payload(got);
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (body_ch.valid && body_ch.ready) || (pay_ch.valid && pay_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_http_chunked_body_decoder: FAIL");
				$finish;
			end
		end
	end

	function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
		if (nib < 4'd10)
			return 8'h30 + 8'(nib);
		return (upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
	endfunction

	// Offer one item, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < in_idle_pct) begin
			body_ch.valid <= 1'b0;
			@(negedge clk);
		end
		body_ch.valid <= 1'b1;
		body_ch.body_byte <= b;
		body_ch.body_last <= last;
		@(posedge clk);
		while (!body_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Send the assembled body, flagging its final byte
	task automatic send_body();
		for (int i = 0; i < body_q.size(); i++)
			send_byte(body_q[i], i == body_q.size() - 1);
	endtask

	// Append a size line: optional white space, hex digits, extension and lone CR, then CR LF
	task automatic put_size_line(input logic [63:0] size, input int min_digits,
		input bit with_digits);
		int         ndig;
		bit         upper;
		logic [7:0] b;
		ndig = 1;
		while (ndig < 16 && (size >> (4 * ndig)) != 0)
			ndig++;
		if (ndig < min_digits)
			ndig = min_digits;
		upper = 1'($urandom_range(1));
		repeat ($urandom_range(0, 2))
			body_q.push_back($urandom_range(1) ? CH_SP : CH_TAB);
		if (with_digits)
			for (int i = ndig - 1; i >= 0; i--)
				body_q.push_back(hex_char(size[4*i +: 4], upper));
		if ($urandom_range(5) == 0) begin
			body_q.push_back(";");
			repeat ($urandom_range(0, 4)) begin
				b = 8'($urandom_range(255));
				body_q.push_back(b == CH_CR ? 8'h78 : b);
			end
		end
		if ($urandom_range(7) == 0) begin
			body_q.push_back(CH_CR);
			body_q.push_back("z");
		end
		body_q.push_back(CH_CR);
		body_q.push_back(CH_LF);
	endtask

	// Build one random body: mostly well formed, some cut, corrupted, oversized or noise
	task automatic build_body();
		int         kind;
		int         size;
		int         nd;
		int         keep;
		logic [63:0] big;
		body_q.delete();
		kind = $urandom_range(99);
		if (kind >= 95) begin
			repeat ($urandom_range(1, 10))
				body_q.push_back(8'($urandom_range(255)));
		end else if (kind >= 90) begin
			// large chunk: the size may saturate, end inside the data
			nd = $urandom_range(8, 12);
			big = {$urandom, $urandom};
			put_size_line(big >> (4 * (16 - nd)), nd, 1'b1);
			repeat ($urandom_range(1, 6))
				body_q.push_back(8'($urandom_range(255)));
		end else begin
			repeat ($urandom_range(0, 3)) begin
				size = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
				put_size_line(64'(size), $urandom_range(1, 3), 1'b1);
				repeat (size)
					body_q.push_back(8'($urandom_range(255)));
				body_q.push_back(CH_CR);
				body_q.push_back(CH_LF);
			end
			// closing line: zero size, or no digit at all
			put_size_line(64'(0), $urandom_range(1, 3), $urandom_range(5) != 0);
			repeat ($urandom_range(0, 2))
				body_q.push_back(8'($urandom_range(255)));
			if (kind >= 80) begin
				body_q[$urandom_range(0, body_q.size() - 1)] = 8'($urandom_range(255));
			end else if (kind >= 70) begin
				keep = $urandom_range(1, body_q.size());
				while (body_q.size() > keep)
					void'(body_q.pop_back());
			end
		end
	endtask

	// Wait for every expected item, then let the pipeline empty
	task automatic settle();
		body_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic run_random(input int idle_pct, input int stall_pct, input int n_items);
		int sent;
		sent = 0;
		in_idle_pct = idle_pct;
		out_stall_pct = stall_pct;
		while (sent < n_items) begin
			build_body();
			send_body();
			sent += body_q.size();
		end
		settle();
	endtask

	initial begin
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		body_ch.valid = 1'b0;
		body_ch.body_byte = 8'h00;
		body_ch.body_last = 1'b0;
		pay_ch.ready = 1'b0;
		in_idle_pct = 0;
		out_stall_pct = 0;
		hold_cnt = 0;
		quiet_cycles = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// well-formed body with leading tab and an all-ones data byte
		body_q = '{CH_TAB, "1", CH_CR, CH_LF, 8'hff, CH_CR, CH_LF, "0", CH_CR, CH_LF};
		send_body();
		// body ends on its first byte, inside the size line
		body_q = '{"A"};
		send_body();
		// size line with no digit ends the body
		body_q = '{CH_CR, CH_LF};
		send_body();
		// wrong byte where CR should follow the data
		body_q = '{"1", CH_CR, CH_LF, 8'h00, "x"};
		send_body();
		// size overflow, body ends before any data
		body_q = '{"f", "f", "f", "f", "f", "f", "f", "f", "f", CH_CR, CH_LF};
		send_body();
		settle();

		run_random(0, 0, 220);
		run_random(45, 0, 220);
		run_random(0, 45, 220);
		run_random(38, 38, 220);

		// hold the receiver off while the sender keeps offering items
		hold_cnt = HOLD_CYCLES;
		run_random(0, 0, 60);

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_http_chunked_body_decoder: PASS");
		else
			$display("tb_http_chunked_body_decoder: FAIL");
		$finish;
	end
endmodule
